@@ rtl/chr_pkg.sv @@
// Shared types, constants and tables for the CAN position range block.
`default_nettype none
package chr_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int NSTEP        = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int SQRT_STEPS   = 31;
    localparam int FIFO_DEPTH   = 4;
    localparam int PADDR_W      = 4;

    typedef struct packed {
        logic [28:0] frame_ident;
        logic [31:0] lat_word;
        logic [31:0] lon_word;
    } in_beat_t;

    typedef struct packed {
        logic        side;
        logic [31:0] distance_cm;
        logic        in_range;
    } out_beat_t;

    typedef struct packed {
        logic        side;
        logic [31:0] lat;
        logic [31:0] lon;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        REG_REF_LAT  = 2'd0,
        REG_REF_LON  = 2'd1,
        REG_MIN_DIST = 2'd2,
        REG_MAX_DIST = 2'd3
    } reg_idx_t;

    localparam logic [28:0] ID_MASK  = 29'h7FF;
    localparam logic [28:0] ID_FRONT = 29'h0D1;
    localparam logic [28:0] ID_REAR  = 29'h0E1;

    localparam logic [27:0] RST_REF_LAT  = 28'd12345678;
    localparam logic [28:0] RST_REF_LON  = 29'd98765432;
    localparam logic [30:0] RST_MIN_DIST = 31'd0;
    localparam logic [30:0] RST_MAX_DIST = 31'd2100000000;

    // angle wrap into [-180e6, 180e6) microdegrees
    localparam logic [32:0]        DEG_WRAP = 33'd360000000;
    localparam logic signed [29:0] DEG_HALF = 30'sd180000000;
    localparam logic signed [34:0] WRAP_OFS = 35'sd2700000000; // half turn plus seven turns

    // pi/180e6 in Q60, split for two narrow multipliers
    localparam logic [34:0] RAD_K   = 35'd20122276271;
    localparam logic [16:0] RAD_KHI = RAD_K[34:18];
    localparam logic [17:0] RAD_KLO = RAD_K[17:0];

    localparam logic signed [33:0] HALFPI30 = 34'sd1686629713;
    localparam logic signed [33:0] PI30     = 34'sd3373259426;
    localparam logic signed [33:0] GAIN30   = 34'sd652032874;
    localparam logic [30:0]        ONE30    = 31'd1073741824;
    localparam logic [30:0]        TWO_RADIUS_CM = 31'd1274200000;

    localparam logic [30:0] ATAN_Q30 [32] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
        31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
        31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
    };

endpackage
`default_nettype wire

@@ rtl/chr_front.sv @@
// Front end: classify the frame identifier and queue position jobs.
`default_nettype none
module chr_front (
    input  wire logic              s_valid,
    input  wire chr_pkg::in_beat_t s_data,
    input  wire chr_pkg::fifo_stat_t stat,
    output logic                   s_ready,
    output logic                   push,
    output chr_pkg::job_t          push_job
);
    import chr_pkg::*;

    logic [28:0] id_masked;
    logic        is_front;
    logic        is_rear;

    assign id_masked = s_data.frame_ident & ID_MASK;
    assign is_front  = (id_masked == ID_FRONT);
    assign is_rear   = (id_masked == ID_REAR);

    // unknown identifiers are taken and dropped
    assign s_ready       = !stat.full;
    assign push          = s_valid && s_ready && (is_front || is_rear);
    assign push_job.side = is_rear;
    assign push_job.lat  = s_data.lat_word;
    assign push_job.lon  = s_data.lon_word;

endmodule
`default_nettype wire

@@ rtl/chr_fifo.sv @@
// Short job queue between front end and math pipeline.
`default_nettype none
module chr_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire chr_pkg::job_t push_job,
    input  wire logic          pop,
    output chr_pkg::job_t      pop_job,
    output chr_pkg::fifo_stat_t stat
);
    import chr_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    job_t          slot_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign stat.full  = (count_reg == CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

@@ rtl/chr_rot.sv @@
// Pipelined rotation CORDIC: sine and cosine of a Q2.30 angle.
`default_nettype none
module chr_rot (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [33:0] z_in,
    output logic signed [31:0]      sin_out,
    output logic signed [31:0]      cos_out
);
    import chr_pkg::*;

    logic signed [33:0] x_reg [0:NSTEP];
    logic signed [33:0] y_reg [0:NSTEP];
    logic signed [33:0] z_reg [0:NSTEP];
    logic               neg_reg [0:NSTEP];
    logic signed [33:0] z_fold;
    logic               neg_fold;
    logic signed [33:0] s_full;
    logic signed [33:0] c_full;

    // fold by pi into the converging range, negate both results later
    always_comb begin
        z_fold   = z_in;
        neg_fold = 1'b0;
        if (z_in > HALFPI30) begin
            z_fold   = z_in - PI30;
            neg_fold = 1'b1;
        end else if (z_in < -HALFPI30) begin
            z_fold   = z_in + PI30;
            neg_fold = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= GAIN30;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_fold;
            neg_reg[0] <= neg_fold;
        end
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        logic signed [33:0] ang;
        assign ang = $signed({3'b000, ATAN_Q30[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ang;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign s_full  = neg_reg[NSTEP] ? -y_reg[NSTEP] : y_reg[NSTEP];
    assign c_full  = neg_reg[NSTEP] ? -x_reg[NSTEP] : x_reg[NSTEP];
    assign sin_out = s_full[31:0];
    assign cos_out = c_full[31:0];

endmodule
`default_nettype wire

@@ rtl/chr_back.sv @@
// Math pipeline: angle wrap, radians, sin/cos, haversine, sqrt, atan2, scaling.
`default_nettype none
module chr_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [27:0]         ref_lat,
    input  wire logic [28:0]         ref_lon,
    input  wire logic [30:0]         min_dist,
    input  wire logic [30:0]         max_dist,
    input  wire chr_pkg::fifo_stat_t stat,
    input  wire chr_pkg::job_t       pop_job,
    output logic                     pop,
    output logic                     m_valid,
    output chr_pkg::out_beat_t       m_data,
    input  wire logic                m_ready
);
    import chr_pkg::*;

    localparam int DEPTH = 43 + 2 * NSTEP;

    logic             adv;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] side_reg;
    logic             m_valid_reg;
    out_beat_t        m_data_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign pop     = adv && !stat.empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[DEPTH-2:0], pop};
            m_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= {side_reg[DEPTH-2:0], pop_job.side};
        end
    end

    // lanes: 0 lat diff, 1 lon diff, 2 frame lat, 3 reference lat
    logic signed [31:0] lat1_s;
    logic signed [31:0] lon1_s;
    logic signed [27:0] lat2_s;
    logic signed [28:0] lon2_s;
    logic signed [34:0] v_next [4];
    logic signed [34:0] u_next [4];
    logic [32:0]        wu_reg [0:4][4];

    assign lat1_s    = $signed(pop_job.lat);
    assign lon1_s    = $signed(pop_job.lon);
    assign lat2_s    = $signed(ref_lat);
    assign lon2_s    = $signed(ref_lon);
    assign v_next[0] = 35'(lat2_s) - 35'(lat1_s);
    assign v_next[1] = 35'(lon2_s) - 35'(lon1_s);
    assign v_next[2] = 35'(lat1_s);
    assign v_next[3] = 35'(lat2_s);

    for (genvar k = 0; k < 4; k++) begin : g_lane
        assign u_next[k] = v_next[k] + WRAP_OFS;
        always_ff @(posedge aclk) begin
            if (adv) begin
                wu_reg[0][k] <= u_next[k][32:0];
            end
        end
    end

    // restoring remainder by 360e6, one quotient bit a stage
    for (genvar j = 0; j < 4; j++) begin : g_wrap
        localparam logic [32:0] STEP_SUB = DEG_WRAP << (3 - j);
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int k = 0; k < 4; k++) begin
                    wu_reg[j+1][k] <= (wu_reg[j][k] >= STEP_SUB) ?
                                      wu_reg[j][k] - STEP_SUB : wu_reg[j][k];
                end
            end
        end
    end

    // microdegrees to radians: split constant product
    logic signed [29:0] d_next   [4];
    logic [27:0]        mag_next [4];
    logic [44:0]        ph_reg   [4];
    logic [45:0]        pl_reg   [4];
    logic               neg_reg  [4];

    for (genvar k = 0; k < 4; k++) begin : g_rad
        logic signed [29:0] d_abs;
        assign d_next[k]   = $signed({1'b0, wu_reg[4][k][28:0]}) - DEG_HALF;
        assign d_abs       = d_next[k][29] ? -d_next[k] : d_next[k];
        assign mag_next[k] = d_abs[27:0];
        always_ff @(posedge aclk) begin
            if (adv) begin
                ph_reg[k]  <= 45'(mag_next[k]) * 45'(RAD_KHI);
                pl_reg[k]  <= 46'(mag_next[k]) * 46'(RAD_KLO);
                neg_reg[k] <= d_next[k][29];
            end
        end
    end

    logic signed [33:0] z_reg [4];

    for (genvar k = 0; k < 4; k++) begin : g_q29
        logic [62:0]        sum;
        logic [30:0]        r;
        logic signed [31:0] q;
        assign sum = {ph_reg[k], 18'b0} + 63'(pl_reg[k]) + (63'(1) << 30);
        assign r   = sum[61:31];
        assign q   = neg_reg[k] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        always_ff @(posedge aclk) begin
            if (adv) begin
                // full latitudes go in doubled: Q3.29 read as Q2.30 is the half angle
                z_reg[k] <= (k >= 2) ? (34'(q) <<< 1) : 34'(q);
            end
        end
    end

    logic signed [31:0] s_w [4];
    logic signed [31:0] c_w [4];

    for (genvar k = 0; k < 4; k++) begin : g_rot
        chr_rot u_rot (
            .aclk    (aclk),
            .en      (adv),
            .z_in    (z_reg[k]),
            .sin_out (s_w[k]),
            .cos_out (c_w[k])
        );
    end

    // haversine term a
    logic signed [63:0] m1a;
    logic signed [63:0] m1b;
    logic signed [63:0] m1c;
    logic signed [63:0] m2;
    logic signed [31:0] p1_reg;
    logic signed [31:0] p2_reg;
    logic signed [31:0] p3_reg;
    logic signed [31:0] p1d_reg;
    logic signed [31:0] p4_reg;
    logic signed [32:0] asum;
    logic [30:0]        a_next;
    logic [30:0]        a_reg;

    assign m1a = 64'(s_w[0]) * 64'(s_w[0]);
    assign m1b = 64'(c_w[2]) * 64'(c_w[3]);
    assign m1c = 64'(s_w[1]) * 64'(s_w[1]);
    assign m2  = 64'(p2_reg) * 64'(p3_reg);

    assign asum = 33'(p1d_reg) + 33'(p4_reg);
    always_comb begin
        if (asum < 0) begin
            a_next = '0;
        end else if (asum > $signed({2'b00, ONE30})) begin
            a_next = ONE30;
        end else begin
            a_next = asum[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg  <= 32'(m1a >>> 30);
            p2_reg  <= 32'(m1b >>> 30);
            p3_reg  <= 32'(m1c >>> 30);
            p1d_reg <= p1_reg;
            p4_reg  <= 32'(m2 >>> 30);
            a_reg   <= a_next;
        end
    end

    // floor square roots of a and 1-a, one result bit a stage
    logic [60:0] sqa_v_reg [0:SQRT_STEPS-1];
    logic [60:0] sqa_r_reg [0:SQRT_STEPS-1];
    logic [60:0] sqb_v_reg [0:SQRT_STEPS-1];
    logic [60:0] sqb_r_reg [0:SQRT_STEPS-1];
    logic [30:0] one_minus_a;

    assign one_minus_a = ONE30 - a_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [60:0] BIT = 61'(1) << (60 - 2 * j);
        logic [60:0] va;
        logic [60:0] ra;
        logic [60:0] vb;
        logic [60:0] rb;
        logic [61:0] ta;
        logic [61:0] tb;
        if (j == 0) begin : g_first
            assign va = {a_reg, 30'b0};
            assign ra = '0;
            assign vb = {one_minus_a, 30'b0};
            assign rb = '0;
        end else begin : g_rest
            assign va = sqa_v_reg[j-1];
            assign ra = sqa_r_reg[j-1];
            assign vb = sqb_v_reg[j-1];
            assign rb = sqb_r_reg[j-1];
        end
        assign ta = 62'(ra) + 62'(BIT);
        assign tb = 62'(rb) + 62'(BIT);
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (62'(va) >= ta) begin
                    sqa_v_reg[j] <= va - ta[60:0];
                    sqa_r_reg[j] <= (ra >> 1) + BIT;
                end else begin
                    sqa_v_reg[j] <= va;
                    sqa_r_reg[j] <= ra >> 1;
                end
                if (62'(vb) >= tb) begin
                    sqb_v_reg[j] <= vb - tb[60:0];
                    sqb_r_reg[j] <= (rb >> 1) + BIT;
                end else begin
                    sqb_v_reg[j] <= vb;
                    sqb_r_reg[j] <= rb >> 1;
                end
            end
        end
    end

    // vectoring CORDIC for atan2(sqrt(a), sqrt(1-a))
    logic signed [33:0] vx_reg [0:NSTEP-1];
    logic signed [33:0] vy_reg [0:NSTEP-1];
    logic signed [33:0] vz_reg [0:NSTEP-1];

    for (genvar i = 0; i < NSTEP; i++) begin : g_vec
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic signed [33:0] ang;
        if (i == 0) begin : g_first
            assign x = $signed({3'b000, sqb_r_reg[SQRT_STEPS-1][30:0]});
            assign y = $signed({3'b000, sqa_r_reg[SQRT_STEPS-1][30:0]});
            assign z = '0;
        end else begin : g_rest
            assign x = vx_reg[i-1];
            assign y = vy_reg[i-1];
            assign z = vz_reg[i-1];
        end
        assign ang = $signed({3'b000, ATAN_Q30[i]});
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (y >= 0) begin
                    vx_reg[i] <= x + (y >>> i);
                    vy_reg[i] <= y - (x >>> i);
                    vz_reg[i] <= z + ang;
                end else begin
                    vx_reg[i] <= x - (y >>> i);
                    vy_reg[i] <= y + (x >>> i);
                    vz_reg[i] <= z - ang;
                end
            end
        end
    end

    // central angle times radius, round, saturate, range check
    logic [30:0] half_ang;
    logic [61:0] prod_reg;
    logic [62:0] rounded;
    logic [32:0] dist_wide;
    logic [31:0] dist_sat;
    logic        in_range;

    assign half_ang  = (vz_reg[NSTEP-1] < 0) ? '0 : vz_reg[NSTEP-1][30:0];
    assign rounded   = 63'(prod_reg) + (63'(1) << 29);
    assign dist_wide = rounded[62:30];
    assign dist_sat  = dist_wide[32] ? '1 : dist_wide[31:0];
    assign in_range  = (dist_sat >= {1'b0, min_dist}) && (dist_sat <= {1'b0, max_dist});

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg                <= 62'(half_ang) * 62'(TWO_RADIUS_CM);
            m_data_reg.side        <= side_reg[DEPTH-1];
            m_data_reg.distance_cm <= dist_sat;
            m_data_reg.in_range    <= in_range;
        end
    end

endmodule
`default_nettype wire

@@ rtl/can_position_haversine_range.sv @@
// Top level: CAN position frames in, great-circle range results out.
//
// Input channel (s_valid/s_ready/s_data): one received CAN frame per beat,
// identifier plus latitude and longitude words in signed microdegrees.
// Frames with identifier 0xD1 (front) or 0xE1 (rear) in the low 11 bits
// produce one result beat; all other frames are taken and dropped.
// Result channel (m_valid/m_ready/m_data): side, distance to the reference
// point in centimetres (saturated) and the in-range flag.
// Throughput: one frame per cycle while the receiver does not stall. The
// pipeline depth is set by the rotation and vectoring CORDIC pipelines,
// the 31-stage square root and the wrap/scale stages.
// A four-entry job queue parts the front end from the math pipeline.
// When the receiver stalls, the whole math pipeline holds; the queue then
// fills and s_ready drops once it is full.
// APB port: ref_latitude at 0x0, ref_longitude at 0x4, min_distance_cm at
// 0x8, max_distance_cm at 0xC. Write only while no frame is in flight.
// Reset (aresetn low, synchronous) empties queue and pipeline, drops any
// pending result and restores the register reset values.
`default_nettype none
module can_position_haversine_range (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire chr_pkg::in_beat_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output chr_pkg::out_beat_t                  m_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [chr_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import chr_pkg::*;

    logic [27:0] ref_lat_reg;
    logic [28:0] ref_lon_reg;
    logic [30:0] min_dist_reg;
    logic [30:0] max_dist_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    // register file: write on the access phase, keep only the field width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_lat_reg  <= RST_REF_LAT;
            ref_lon_reg  <= RST_REF_LON;
            min_dist_reg <= RST_MIN_DIST;
            max_dist_reg <= RST_MAX_DIST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_REF_LAT: begin
                    ref_lat_reg <= pwdata[27:0];
                end
                REG_REF_LON: begin
                    ref_lon_reg <= pwdata[28:0];
                end
                REG_MIN_DIST: begin
                    min_dist_reg <= pwdata[30:0];
                end
                REG_MAX_DIST: begin
                    max_dist_reg <= pwdata[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    // read back raw field bits, zero-extended
    always_comb begin
        case (cfg_idx)
            REG_REF_LAT:  prdata = 32'(ref_lat_reg);
            REG_REF_LON:  prdata = 32'(ref_lon_reg);
            REG_MIN_DIST: prdata = 32'(min_dist_reg);
            REG_MAX_DIST: prdata = 32'(max_dist_reg);
            default:      prdata = '0;
        endcase
    end

    fifo_stat_t stat;
    logic       push;
    logic       pop;
    job_t       push_job;
    job_t       pop_job;

    // front end: classify identifier, drop unknown frames, queue the rest
    chr_front u_front (
        .s_valid  (s_valid),
        .s_data   (s_data),
        .stat     (stat),
        .s_ready  (s_ready),
        .push     (push),
        .push_job (push_job)
    );

    // queue lets the front keep taking beats while the back end holds
    chr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (stat)
    );

    // back end: fixed-point haversine pipeline with output register
    chr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ref_lat  (ref_lat_reg),
        .ref_lon  (ref_lon_reg),
        .min_dist (min_dist_reg),
        .max_dist (max_dist_reg),
        .stat     (stat),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_data   (m_data),
        .m_ready  (m_ready)
    );

endmodule
`default_nettype wire

@@ rtl/chr_checker.sv @@
// Port-level assertions for the range block, bound to the top level.
`default_nettype none
module chr_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire chr_pkg::out_beat_t m_data
);
    import chr_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // the upper bound fits in 31 bits, so an in-range distance does too
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.in_range |-> !m_data.distance_cm[31])
        else $error("in-range flag set above the largest allowed bound");

endmodule

bind can_position_haversine_range chr_checker u_chr_checker (.*);
`default_nettype wire

@@ tb/sv/can_position_haversine_range_tb.sv @@
// Testbench for the CAN position haversine range block: predictor, scoreboard, drivers.
`timescale 1ns / 1ps
`default_nettype none

class range_scoreboard;
    chr_pkg::out_beat_t pending_ranges[$];
    int                 fails;
    logic [27:0]        ref_lat;
    logic [28:0]        ref_lon;
    logic [30:0]        min_cm;
    logic [30:0]        max_cm;
    longint             arctan_tab[32];

    function new();
        arctan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
            16, 8, 4, 2, 1, 0};
        fails   = 0;
        ref_lat = 28'd12345678;
        ref_lon = 29'd98765432;
        min_cm  = 31'd0;
        max_cm  = 31'd2100000000;
    endfunction

    function void set_reg(chr_pkg::reg_idx_t idx, logic [31:0] v);
        case (idx)
            chr_pkg::REG_REF_LAT:  ref_lat = v[27:0];
            chr_pkg::REG_REF_LON:  ref_lon = v[28:0];
            chr_pkg::REG_MIN_DIST: min_cm  = v[30:0];
            chr_pkg::REG_MAX_DIST: max_cm  = v[30:0];
            default: ;
        endcase
    endfunction

    function longint wrap_udeg(longint v);
        longint r;
        r = v % 64'sd360000000;
        if (r >= 64'sd180000000) r -= 64'sd360000000;
        if (r < -64'sd180000000) r += 64'sd360000000;
        return r;
    endfunction

    function longint udeg_to_rad29(longint d);
        longint unsigned u, r;
        u = (d < 0) ? -d : d;
        r = (u * 64'd20122276271 + (64'd1 << 30)) >> 31;
        return (d < 0) ? -longint'(r) : longint'(r);
    endfunction

    function void sin_cos(longint z, output longint s, output longint c);
        longint x, y, nx;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426; flip = 1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426; flip = 1;
        end
        for (int i = 0; i < chr_pkg::NSTEP; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_tab[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_tab[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function longint arctan2(longint y, longint x);
        longint z, nx;
        z = 0;
        for (int i = 0; i < chr_pkg::NSTEP; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_tab[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_tab[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Predict the range beat of one accepted frame; drop unknown identifiers.
    function void note_frame(chr_pkg::in_beat_t f);
        chr_pkg::out_beat_t exp_beat;
        logic [10:0]     id;
        longint          lat1, lon1, lat2, lon2, sdl, cdl, sdo, cdo, s1, c1, s2, c2, a, ang;
        longint unsigned dist_cm;
        id = f.frame_ident[10:0];
        if (id == 11'h0D1) exp_beat.side = 1'b0;
        else if (id == 11'h0E1) exp_beat.side = 1'b1;
        else return;
        lat1 = longint'($signed(f.lat_word));
        lon1 = longint'($signed(f.lon_word));
        lat2 = longint'($signed(ref_lat));
        lon2 = longint'($signed(ref_lon));
        sin_cos(udeg_to_rad29(wrap_udeg(lat2 - lat1)), sdl, cdl);
        sin_cos(udeg_to_rad29(wrap_udeg(lon2 - lon1)), sdo, cdo);
        sin_cos(udeg_to_rad29(wrap_udeg(lat1)) * 2, s1, c1);
        sin_cos(udeg_to_rad29(wrap_udeg(lat2)) * 2, s2, c2);
        a = ((sdl * sdl) >>> 30) + ((((c1 * c2) >>> 30) * ((sdo * sdo) >>> 30)) >>> 30);
        if (a < 0) a = 0;
        if (a > 64'sd1073741824) a = 64'sd1073741824;
        ang = arctan2(longint'(floor_sqrt(longint'(a) << 30)),
                      longint'(floor_sqrt(longint'(64'sd1073741824 - a) << 30)));
        if (ang < 0) ang = 0;
        ang *= 2;
        dist_cm = (longint'(ang) * 64'd637100000 + (64'd1 << 29)) >> 30;
        if (dist_cm > 64'hFFFFFFFF) dist_cm = 64'hFFFFFFFF;
        exp_beat.distance_cm = dist_cm[31:0];
        exp_beat.in_range = (dist_cm >= min_cm) && (dist_cm <= max_cm);
        pending_ranges.push_back(exp_beat);
    endfunction

    function void check_beat(chr_pkg::out_beat_t got);
        chr_pkg::out_beat_t exp_beat;
        if (pending_ranges.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            fails++;
            return;
        end
        exp_beat = pending_ranges.pop_front();
        if (got.side !== exp_beat.side) begin
            $display("%0t: side expected %0d actual %0d", $time, exp_beat.side, got.side);
            fails++;
        end
        if (got.distance_cm !== exp_beat.distance_cm) begin
            $display("%0t: distance_cm expected %0d actual %0d", $time,
                     exp_beat.distance_cm, got.distance_cm);
            fails++;
        end
        if (got.in_range !== exp_beat.in_range) begin
            $display("%0t: in_range expected %0d actual %0d", $time,
                     exp_beat.in_range, got.in_range);
            fails++;
        end
    endfunction
endclass

module can_position_haversine_range_tb;
    import chr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 150;     // comfortably above the pipe latency

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    range_scoreboard sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          cycles;

    can_position_haversine_range dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Watchdog: end the run if the pipeline never drains.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall at random with the phase's stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor both channels on pre-edge values; note frames, check results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_frame(s_data);
            if (m_valid && m_ready) sb.check_beat(m_data);
        end
    end

    // Send one frame beat; idle first at the phase's rate, then hold until taken.
    task automatic drive_beat(in_beat_t f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_pos(logic [28:0] id, logic [31:0] lat, logic [31:0] lon);
        in_beat_t f;
        f.frame_ident = id;
        f.lat_word    = lat;
        f.lon_word    = lon;
        drive_beat(f);
    endtask

    // APB write: setup beat, then access beat until pready, then back to idle.
    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    // Drop valid, wait for every expected beat, then let dropped frames flush.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_ranges.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_window(int unsigned lo, int unsigned hi);
        write_reg(REG_MIN_DIST, lo);
        write_reg(REG_MAX_DIST, hi);
    endtask

    // Random frame: mostly known ids with random upper bits, some near the reference.
    task automatic send_random();
        logic [28:0] id;
        logic [31:0] lat, lon;
        int          pick;
        id   = 29'($urandom);
        pick = $urandom_range(99);
        if (pick < 42) id[10:0] = 11'h0D1;
        else if (pick < 84) id[10:0] = 11'h0E1;
        if ($urandom_range(1)) begin
            lat = $urandom;
            lon = $urandom;
        end else begin
            lat = $signed(sb.ref_lat) + $signed($urandom_range(4000000)) - 2000000;
            lon = $signed(sb.ref_lon) + $signed($urandom_range(4000000)) - 2000000;
        end
        send_pos(id, lat, lon);
    endtask

    initial begin
        int phase_items;
        sb             = new();
        cycles         = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset registers, extremes of every field, unknown ids.
        send_pos(29'h0D1, 32'd12345678, 32'd98765432);        // on the reference
        send_pos(29'h0E1, 32'h7FFFFFFF, 32'h80000000);
        send_pos(29'h1FFFF8D1, 32'h80000000, 32'h7FFFFFFF);   // upper id bits ignored
        send_pos(29'h1FFFF8E1, 32'h0, 32'hFFFFFFFF);
        send_pos(29'h0D0, 32'd1, 32'd1);                      // unknown id
        send_pos(29'h1FFFFFFF, 32'hFFFFFFFF, 32'h0);
        send_pos(29'h0E1, -32'sd12345678, -32'sd81234568);   // antipode
        send_pos(29'h0D1, 32'd135000000, 32'd0);              // latitude past the pole
        send_pos(29'h0D1, -32'sd100000000, 32'd179999999);
        drain();
        write_reg(REG_REF_LAT, 32'd90000000);
        write_reg(REG_REF_LON, -32'sd180000000);
        set_window(500000000, 1500000000);
        send_pos(29'h0D1, 32'd90000000, 32'd0);
        send_pos(29'h0E1, -32'sd90000000, 32'd180000000);
        send_pos(29'h0D1, 32'd0, 32'd90000000);
        send_pos(29'h0E1, 32'd45000000, -32'sd45000000);
        drain();
        write_reg(REG_REF_LAT, -32'sd90000000);
        write_reg(REG_REF_LON, 32'd180000000);
        set_window(1500000000, 500000000);                    // minimum above maximum
        send_pos(29'h0D1, 32'd0, 32'd0);
        send_pos(29'h0E1, 32'd89999999, 32'd1);
        send_pos(29'h0D1, -32'sd90000000, 32'd180000000);
        drain();
        write_reg(REG_REF_LAT, 32'd0);
        write_reg(REG_REF_LON, 32'd0);
        set_window(0, 0);
        send_pos(29'h0D1, 32'd0, 32'd0);
        send_pos(29'h0E1, 32'd1, 32'd0);
        drain();

        // Random phases: cycle through idle modes and register settings.
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            write_reg(REG_REF_LAT, $signed($urandom_range(180000000)) - 90000000);
            write_reg(REG_REF_LON, $signed($urandom_range(360000000)) - 180000000);
            case (ph % 3)
                0: set_window(0, 2100000000);
                1: set_window($urandom_range(20000000), $urandom_range(40000000));
                default: set_window($urandom_range(2100000000), $urandom_range(2100000000));
            endcase
            phase_items = 120;
            for (int n = 0; n < phase_items; n++) begin
                // Add a no-idle burst midway to cover back-to-back beats.
                if (n == phase_items / 2 && send_idle_pct != 0) send_idle_pct = 0;
                send_random();
            end
            drain();
        end

        s_valid <= 1'b0;
        while (sb.pending_ranges.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

`default_nettype wire

@@ can_position_haversine_range.f @@
rtl/chr_pkg.sv
rtl/chr_front.sv
rtl/chr_fifo.sv
rtl/chr_rot.sv
rtl/chr_back.sv
rtl/can_position_haversine_range.sv
rtl/chr_checker.sv
tb/sv/can_position_haversine_range_tb.sv
